### hdl/gtces_pkg.sv
// ----------------------------------------------------------------------------
// Grid tile sorter package
// Shared widths, codes, the compare-exchange network table and the color
// wheel used by the grid tile compare-exchange sorter.
// ----------------------------------------------------------------------------
package gtces_pkg;

   localparam int MAX_PIXELS  = 4096;
   localparam int ADDR_W      = $clog2(MAX_PIXELS);
   localparam int POS_W       = ADDR_W + 1;
   localparam int HUE_W       = 13;
   localparam int DIM_W       = 7;
   localparam int MODE_W      = 3;
   localparam int STEP_W      = 3;
   localparam int CHANCE_W    = 2;
   localparam int CNT_W       = 14;
   localparam int FRAME_W     = 16;
   localparam int THIRD_W     = FRAME_W - 1;
   localparam int CSR_IDX_W   = 2;
   localparam int REM_STEPS   = POS_W;
   localparam int REM_CNT_W   = $clog2(REM_STEPS + 1);
   localparam int COLOR_W     = 8;
   localparam int SECTOR_W    = HUE_W - COLOR_W;

   localparam logic [DIM_W-1:0]   DIM_MIN      = 7'd2;
   localparam logic [DIM_W-1:0]   DIM_MAX      = 7'd64;
   localparam logic [DIM_W-1:0]   DIM_RESET    = 7'd64;
   localparam logic [DIM_W-1:0]   BORING_RESET = 7'd8;
   localparam logic [CNT_W-1:0]   CNT_MAX      = '1;
   localparam logic [FRAME_W-1:0] FRAME_MAX    = '1;
   localparam logic [COLOR_W-1:0] WHEEL_MAX    = '1;
   localparam int                 PCT_SCALE    = 100;
   // frame / 3 == (frame * THIRD_RECIP) >> THIRD_SHIFT for any 16-bit frame
   localparam int                 THIRD_RECIP  = 43691;
   localparam int                 THIRD_SHIFT  = 17;
   localparam int                 WHEEL_SECTORS = 6;

   typedef enum logic [1:0] {
      ACT_LOAD = 2'd0,
      ACT_SORT = 2'd1,
      ACT_FEND = 2'd2,
      ACT_READ = 2'd3
   } action_type;

   localparam logic [CSR_IDX_W-1:0] CSR_GRID_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_START_MODE  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BORING_PCT  = 2'd3;

   localparam logic [MODE_W-1:0] MODE_0 = 3'd0;
   localparam logic [MODE_W-1:0] MODE_1 = 3'd1;
   localparam logic [MODE_W-1:0] MODE_2 = 3'd2;
   localparam logic [MODE_W-1:0] MODE_3 = 3'd3;
   localparam logic [MODE_W-1:0] MODE_4 = 3'd4;

   // tile corners: A = p, B = p+1, C = p+W, D = p+W+1
   typedef enum logic [1:0] {
      CORNER_A = 2'd0,
      CORNER_B = 2'd1,
      CORNER_C = 2'd2,
      CORNER_D = 2'd3
   } corner_type;

   typedef struct packed {
      corner_type x;
      corner_type y;
      logic       last;
   } xop_type;

   typedef struct packed {
      logic             done;
      logic [DIM_W-1:0] rem;
   } rem_result_type;

   typedef struct packed {
      logic [COLOR_W-1:0] r;
      logic [COLOR_W-1:0] g;
      logic [COLOR_W-1:0] b;
   } rgb_type;

   // Exchange number idx of the network in the given mode; (x,y) swaps when x < y.
   function automatic xop_type net_op(logic [MODE_W-1:0] mode, logic [1:0] idx);
      xop_type op;
      unique case (mode)
         MODE_1: begin
            unique case (idx)
               2'd0:    op = '{CORNER_D, CORNER_A, 1'b0};
               2'd1:    op = '{CORNER_C, CORNER_B, 1'b0};
               default: op = '{CORNER_D, CORNER_C, 1'b1};
            endcase
         end
         MODE_2: begin
            unique case (idx)
               2'd0:    op = '{CORNER_A, CORNER_D, 1'b0};
               default: op = '{CORNER_A, CORNER_C, 1'b1};
            endcase
         end
         MODE_3: begin
            unique case (idx)
               2'd0:    op = '{CORNER_D, CORNER_A, 1'b0};
               default: op = '{CORNER_D, CORNER_C, 1'b1};
            endcase
         end
         MODE_4: begin
            unique case (idx)
               2'd0:    op = '{CORNER_C, CORNER_B, 1'b0};
               2'd1:    op = '{CORNER_A, CORNER_D, 1'b0};
               default: op = '{CORNER_D, CORNER_A, 1'b1};
            endcase
         end
         default: begin
            unique case (idx)
               2'd0:    op = '{CORNER_A, CORNER_D, 1'b0};
               2'd1:    op = '{CORNER_C, CORNER_B, 1'b0};
               default: op = '{CORNER_A, CORNER_C, 1'b1};
            endcase
         end
      endcase
      return op;
   endfunction

   function automatic rgb_type wheel(logic [HUE_W-1:0] h);
      logic [SECTOR_W-1:0] sec;
      logic [COLOR_W-1:0]  v;
      rgb_type             c;
      sec = h[HUE_W-1:COLOR_W];
      v   = h[COLOR_W-1:0];
      // reduce the sector modulo six by compare and subtract
      if (sec >= SECTOR_W'(4 * WHEEL_SECTORS)) sec = sec - SECTOR_W'(4 * WHEEL_SECTORS);
      if (sec >= SECTOR_W'(2 * WHEEL_SECTORS)) sec = sec - SECTOR_W'(2 * WHEEL_SECTORS);
      if (sec >= SECTOR_W'(WHEEL_SECTORS))     sec = sec - SECTOR_W'(WHEEL_SECTORS);
      unique case (sec)
         SECTOR_W'(0): c = '{WHEEL_MAX, v, '0};
         SECTOR_W'(1): c = '{WHEEL_MAX - v, WHEEL_MAX, '0};
         SECTOR_W'(2): c = '{'0, WHEEL_MAX, v};
         SECTOR_W'(3): c = '{'0, WHEEL_MAX - v, WHEEL_MAX};
         SECTOR_W'(4): c = '{v, '0, WHEEL_MAX};
         default:      c = '{WHEEL_MAX, '0, WHEEL_MAX - v};
      endcase
      return c;
   endfunction

endpackage

### hdl/gtces_rem.sv
// ----------------------------------------------------------------------------
// Walk position remainder unit
// Restoring shift-subtract remainder of the walk position by the grid
// width, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gtces_rem (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [gtces_pkg::POS_W-1:0]     dividend,
   input  logic [gtces_pkg::DIM_W-1:0]     divisor,
   output gtces_pkg::rem_result_type       result
);

   logic [gtces_pkg::POS_W-1:0]     dvd_ff, dvd_in;
   logic [gtces_pkg::DIM_W-1:0]     dsr_ff, dsr_in;
   logic [gtces_pkg::DIM_W-1:0]     rem_ff, rem_in;
   logic [gtces_pkg::REM_CNT_W-1:0] cnt_ff, cnt_in;
   logic                            run_ff, run_in;
   logic                            done_ff, done_in;
   logic [gtces_pkg::DIM_W-1:0]     trial;

   // remainder stays below the divisor (at most 64), so one bit shifts in clean
   assign trial = {rem_ff[gtces_pkg::DIM_W-2:0], dvd_ff[gtces_pkg::POS_W-1]};

   always_comb begin
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         dvd_in = dividend;
         dsr_in = divisor;
         rem_in = '0;
         cnt_in = gtces_pkg::REM_CNT_W'(gtces_pkg::REM_STEPS);
         run_in = 1'b1;
      end else if (run_ff) begin
         rem_in = (trial >= dsr_ff) ? trial - dsr_ff : trial;
         dvd_in = dvd_ff << 1;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == gtces_pkg::REM_CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
      rem_ff <= rem_in;
   end

   assign result.done = done_ff;
   assign result.rem  = rem_ff;

endmodule

### hdl/grid_tile_compare_exchange_sorter.sv
// ----------------------------------------------------------------------------
// Grid tile compare-exchange sorter
// Holds a grid of hue values in one memory and sorts it tile by tile with a
// 2x2 compare-exchange network, runs the frame-end boredom test and mode
// countdown, and returns pixels with their color-wheel RGB.
// ----------------------------------------------------------------------------
// A sort step with a tile waits on the 13-step remainder unit (walk column),
//    then runs each exchange on the one memory port (read, read, compare and
//    write, write on a swap).
// Busy is high while an item is at work; a new item is taken only while idle.
// The result strobe lasts one cycle and cannot be held off.
// Reset is synchronous: it clears the control registers, not the payload registers or the grid.
module grid_tile_compare_exchange_sorter (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [1:0]                         req_action,
   input  logic [gtces_pkg::ADDR_W-1:0]       req_pixel_index,
   input  logic [gtces_pkg::HUE_W-1:0]        req_pixel_value,
   input  logic [gtces_pkg::STEP_W-1:0]       req_walk_step,
   input  logic [gtces_pkg::CHANCE_W-1:0]     req_mode_chance,
   output logic                               rsp_valid,
   output logic [gtces_pkg::HUE_W-1:0]        rsp_read_value,
   output logic [gtces_pkg::COLOR_W-1:0]      rsp_red,
   output logic [gtces_pkg::COLOR_W-1:0]      rsp_green,
   output logic [gtces_pkg::COLOR_W-1:0]      rsp_blue,
   output logic [1:0]                         rsp_swaps_made,
   output logic                               rsp_sweep_done,
   output logic                               rsp_exit_now,
   output logic [gtces_pkg::MODE_W-1:0]       rsp_current_mode,
   output logic                               rsp_bad_index,
   input  logic                               csr_we,
   input  logic [gtces_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [gtces_pkg::DIM_W-1:0]        csr_wdata
);

   // Sequencer: one-hot states
   typedef enum logic [7:0] {
      ST_IDLE = 8'b0000_0001,
      ST_READ = 8'b0000_0010,  // registered memory data for a read item
      ST_REM  = 8'b0000_0100,  // wait for walk column from the remainder unit
      ST_XA   = 8'b0000_1000,  // issue read of the first corner
      ST_XB   = 8'b0001_0000,  // issue read of the second corner, hold first
      ST_XC   = 8'b0010_0000,  // compare, write first corner on a swap
      ST_XD   = 8'b0100_0000,  // write second corner
      ST_FEND = 8'b1000_0000   // boredom test and countdown
   } state_type;

   state_type state_ff, state_in;

   // configuration registers
   logic [gtces_pkg::DIM_W-1:0]   grid_width_ff, grid_width_in;
   logic [gtces_pkg::DIM_W-1:0]   grid_height_ff, grid_height_in;
   logic [gtces_pkg::MODE_W-1:0]  start_mode_ff, start_mode_in;
   logic [gtces_pkg::DIM_W-1:0]   boring_pct_ff, boring_pct_in;

   // sorter state
   logic [gtces_pkg::POS_W-1:0]   walk_pos_ff, walk_pos_in;
   logic [gtces_pkg::MODE_W-1:0]  mode_ff, mode_in;
   logic [gtces_pkg::CNT_W-1:0]   hot_ff, hot_in;
   logic [gtces_pkg::CNT_W-1:0]   cold_ff, cold_in;
   logic [gtces_pkg::FRAME_W-1:0] frame_ff, frame_in;
   logic [gtces_pkg::FRAME_W-1:0] countdown_ff, countdown_in;

   // per-item working registers
   logic [gtces_pkg::POS_W-1:0]       pos_ff, pos_in;
   logic [1:0]                        op_idx_ff, op_idx_in;
   logic [1:0]                        swaps_ff, swaps_in;
   logic [gtces_pkg::HUE_W-1:0]       vx_ff, vx_in;
   logic [gtces_pkg::CHANCE_W-1:0]    chance_ff, chance_in;
   logic [2*gtces_pkg::DIM_W+gtces_pkg::CNT_W-1:0] hot100_ff, hot100_in;
   logic [2*gtces_pkg::DIM_W+gtces_pkg::CNT_W:0]   bpt_ff, bpt_in;
   logic [gtces_pkg::THIRD_W-1:0]     third_ff, third_in;

   // result registers
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [gtces_pkg::HUE_W-1:0]       rsp_read_value_ff, rsp_read_value_in;
   gtces_pkg::rgb_type                rsp_rgb_ff, rsp_rgb_in;
   logic [1:0]                        rsp_swaps_ff, rsp_swaps_in;
   logic                              rsp_sweep_ff, rsp_sweep_in;
   logic                              rsp_exit_ff, rsp_exit_in;
   logic [gtces_pkg::MODE_W-1:0]      rsp_mode_ff, rsp_mode_in;
   logic                              rsp_bad_ff, rsp_bad_in;

   // grid memory: one write and one registered read per cycle
   logic [gtces_pkg::HUE_W-1:0]       pixel_mem [gtces_pkg::MAX_PIXELS];
   logic [gtces_pkg::HUE_W-1:0]       mem_rdata_ff;
   logic                              mem_we;
   logic [gtces_pkg::ADDR_W-1:0]      mem_waddr;
   logic [gtces_pkg::HUE_W-1:0]       mem_wdata;
   logic [gtces_pkg::ADDR_W-1:0]      mem_raddr;

   // remainder unit
   logic                              rem_start;
   gtces_pkg::rem_result_type         rem_res;

   // derived grid geometry
   logic [gtces_pkg::DIM_W-1:0]       width_eff;
   logic [gtces_pkg::DIM_W-1:0]       height_eff;
   logic [2*gtces_pkg::DIM_W-1:0]     area_full;
   logic [gtces_pkg::POS_W-1:0]       grid_size;
   logic                              index_bad;
   logic [gtces_pkg::POS_W:0]         walk_end;
   logic                              walk_past;

   gtces_pkg::xop_type                op;
   gtces_pkg::corner_type             corner_sel;
   logic [gtces_pkg::ADDR_W-1:0]      corner_addr;

   // Saturate a dimension register to the range 2..64.
   function automatic logic [gtces_pkg::DIM_W-1:0] clamp_dim(logic [gtces_pkg::DIM_W-1:0] v);
      logic [gtces_pkg::DIM_W-1:0] r;
      r = v;
      if (v < gtces_pkg::DIM_MIN) r = gtces_pkg::DIM_MIN;
      else if (v > gtces_pkg::DIM_MAX) r = gtces_pkg::DIM_MAX;
      return r;
   endfunction

   assign width_eff  = clamp_dim(grid_width_ff);
   assign height_eff = clamp_dim(grid_height_ff);
   assign area_full  = (2*gtces_pkg::DIM_W)'(width_eff) * (2*gtces_pkg::DIM_W)'(height_eff);
   // 64 x 64 fills the grid exactly, so the product never exceeds it
   assign grid_size  = area_full[gtces_pkg::POS_W-1:0];
   assign index_bad  = gtces_pkg::POS_W'(req_pixel_index) >= grid_size;

   // a walk whose tile bottom-right corner leaves the grid is finished
   assign walk_end  = (gtces_pkg::POS_W+1)'(walk_pos_ff) + (gtces_pkg::POS_W+1)'(width_eff)
                      + (gtces_pkg::POS_W+1)'(1);
   assign walk_past = walk_end >= (gtces_pkg::POS_W+1)'(grid_size);

   // network exchange and the corner address for this cycle
   assign op         = gtces_pkg::net_op(mode_ff, op_idx_ff);
   assign corner_sel = ((state_ff == ST_XB) || (state_ff == ST_XD)) ? op.y : op.x;

   always_comb begin
      logic [gtces_pkg::POS_W-1:0] off;
      logic [gtces_pkg::POS_W-1:0] sum;
      unique case (corner_sel)
         gtces_pkg::CORNER_A: off = '0;
         gtces_pkg::CORNER_B: off = gtces_pkg::POS_W'(1);
         gtces_pkg::CORNER_C: off = gtces_pkg::POS_W'(width_eff);
         gtces_pkg::CORNER_D: off = gtces_pkg::POS_W'(width_eff) + gtces_pkg::POS_W'(1);
      endcase
      sum         = pos_ff + off;
      // a tile that is exchanged lies wholly inside the grid
      corner_addr = sum[gtces_pkg::ADDR_W-1:0];
   end

   gtces_rem u_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (rem_start),
      .dividend (pos_in),
      .divisor  (width_eff),
      .result   (rem_res)
   );

   // Main sequencer
   always_comb begin
      logic [gtces_pkg::POS_W-1:0]   p_adj;
      logic [gtces_pkg::POS_W:0]     adj_end;
      logic                          boring;
      logic [gtces_pkg::FRAME_W:0]   cd_sum;
      logic [gtces_pkg::FRAME_W-1:0] cd_next;
      logic [gtces_pkg::MODE_W-1:0]  mode_next;
      logic                          ex;
      logic [2*gtces_pkg::FRAME_W-1:0] third_prod;
      logic [gtces_pkg::CNT_W:0]     total;
      logic                          advance;

      p_adj      = '0;
      adj_end    = '0;
      boring     = 1'b0;
      cd_sum     = '0;
      cd_next    = countdown_ff;
      mode_next  = mode_ff;
      ex         = 1'b0;
      third_prod = '0;
      total      = '0;
      advance    = 1'b0;

      state_in       = state_ff;
      grid_width_in  = grid_width_ff;
      grid_height_in = grid_height_ff;
      start_mode_in  = start_mode_ff;
      boring_pct_in  = boring_pct_ff;
      walk_pos_in    = walk_pos_ff;
      mode_in        = mode_ff;
      hot_in         = hot_ff;
      cold_in        = cold_ff;
      frame_in       = frame_ff;
      countdown_in   = countdown_ff;
      pos_in         = pos_ff;
      op_idx_in      = op_idx_ff;
      swaps_in       = swaps_ff;
      vx_in          = vx_ff;
      chance_in      = chance_ff;
      hot100_in      = hot100_ff;
      bpt_in         = bpt_ff;
      third_in       = third_ff;

      // results default to an all-zero item in the current mode
      rsp_valid_in      = 1'b0;
      rsp_read_value_in = '0;
      rsp_rgb_in        = '0;
      rsp_swaps_in      = '0;
      rsp_sweep_in      = 1'b0;
      rsp_exit_in       = 1'b0;
      rsp_mode_in       = mode_ff;
      rsp_bad_in        = 1'b0;

      mem_we    = 1'b0;
      mem_waddr = corner_addr;
      mem_wdata = mem_rdata_ff;
      mem_raddr = corner_addr;
      rem_start = 1'b0;

      // configuration writes must arrive only while idle; the block does not enforce this
      if (csr_we) begin
         unique case (csr_index)
            gtces_pkg::CSR_GRID_WIDTH:  grid_width_in  = csr_wdata;
            gtces_pkg::CSR_GRID_HEIGHT: grid_height_in = csr_wdata;
            gtces_pkg::CSR_START_MODE:  start_mode_in  = csr_wdata[gtces_pkg::MODE_W-1:0];
            gtces_pkg::CSR_BORING_PCT:  boring_pct_in  = csr_wdata;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            mem_raddr = req_pixel_index;
            if (start) begin
               unique case (gtces_pkg::action_type'(req_action))
                  gtces_pkg::ACT_LOAD: begin
                     // store the hue unless the index is off the grid
                     mem_we       = !index_bad;
                     mem_waddr    = req_pixel_index;
                     mem_wdata    = req_pixel_value;
                     rsp_bad_in   = index_bad;
                     rsp_valid_in = 1'b1;
                  end
                  gtces_pkg::ACT_READ: begin
                     if (index_bad) begin
                        rsp_bad_in   = 1'b1;
                        rsp_valid_in = 1'b1;
                     end else begin
                        state_in = ST_READ;
                     end
                  end
                  gtces_pkg::ACT_SORT: begin
                     if (walk_past) begin
                        rsp_sweep_in = 1'b1;
                        rsp_valid_in = 1'b1;
                     end else begin
                        // advance the walk, then find its column
                        pos_in    = walk_pos_ff + gtces_pkg::POS_W'(req_walk_step);
                        rem_start = 1'b1;
                        state_in  = ST_REM;
                     end
                  end
                  gtces_pkg::ACT_FEND: begin
                     // register the boredom products and frame / 3
                     total      = (gtces_pkg::CNT_W+1)'(hot_ff) + (gtces_pkg::CNT_W+1)'(cold_ff);
                     hot100_in  = $bits(hot100_in)'(hot_ff) * $bits(hot100_in)'(gtces_pkg::PCT_SCALE);
                     bpt_in     = $bits(bpt_in)'(boring_pct_ff) * $bits(bpt_in)'(total);
                     third_prod = (2*gtces_pkg::FRAME_W)'(frame_ff)
                                  * (2*gtces_pkg::FRAME_W)'(gtces_pkg::THIRD_RECIP);
                     third_in   = third_prod[gtces_pkg::THIRD_SHIFT +: gtces_pkg::THIRD_W];
                     chance_in  = req_mode_chance;
                     state_in   = ST_FEND;
                  end
               endcase
            end
         end

         ST_READ: begin
            rsp_read_value_in = mem_rdata_ff;
            rsp_rgb_in        = gtces_pkg::wheel(mem_rdata_ff);
            rsp_valid_in      = 1'b1;
            state_in          = ST_IDLE;
         end

         ST_REM: begin
            if (rem_res.done) begin
               // skip the last column: a tile needs its right neighbor
               p_adj = pos_ff;
               if (rem_res.rem == width_eff - 1'b1) p_adj = pos_ff + 1'b1;
               walk_pos_in = p_adj;
               pos_in      = p_adj;
               adj_end     = (gtces_pkg::POS_W+1)'(p_adj) + (gtces_pkg::POS_W+1)'(width_eff)
                             + (gtces_pkg::POS_W+1)'(1);
               if (adj_end >= (gtces_pkg::POS_W+1)'(grid_size)) begin
                  rsp_sweep_in = 1'b1;
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end else begin
                  op_idx_in = '0;
                  swaps_in  = '0;
                  state_in  = ST_XA;
               end
            end
         end

         ST_XA: begin
            state_in = ST_XB;
         end

         ST_XB: begin
            vx_in    = mem_rdata_ff;
            state_in = ST_XC;
         end

         ST_XC: begin
            // larger value moves to the first corner
            if (vx_ff < mem_rdata_ff) begin
               mem_we    = 1'b1;
               mem_wdata = mem_rdata_ff;
               if (hot_ff != gtces_pkg::CNT_MAX) hot_in = hot_ff + 1'b1;
               swaps_in  = swaps_ff + 1'b1;
               state_in  = ST_XD;
            end else begin
               if (cold_ff != gtces_pkg::CNT_MAX) cold_in = cold_ff + 1'b1;
               advance = 1'b1;
            end
         end

         ST_XD: begin
            mem_we    = 1'b1;
            mem_wdata = vx_ff;
            advance   = 1'b1;
         end

         ST_FEND: begin
            boring = $bits(bpt_ff)'(hot100_ff) < bpt_ff;
            if (boring) begin
               priority if (mode_ff == gtces_pkg::MODE_0) begin
                  mode_next = (chance_ff != '0) ? gtces_pkg::MODE_1 : gtces_pkg::MODE_4;
                  cd_sum    = (gtces_pkg::FRAME_W+1)'(frame_ff) + (gtces_pkg::FRAME_W+1)'(third_ff);
                  cd_next   = cd_sum[gtces_pkg::FRAME_W] ? gtces_pkg::FRAME_MAX
                                                         : cd_sum[gtces_pkg::FRAME_W-1:0];
               end else if (mode_ff == gtces_pkg::MODE_1) begin
                  ex = 1'b1;
               end else if (mode_ff == gtces_pkg::MODE_2) begin
                  if (countdown_ff == '0) cd_next = gtces_pkg::FRAME_W'(third_ff);
               end else begin
                  // other modes keep their course
                  mode_next = mode_ff;
               end
            end
            if (cd_next != '0) begin
               cd_next = cd_next - 1'b1;
               if (cd_next == '0) ex = 1'b1;
            end
            if (ex) begin
               mode_in      = start_mode_ff;
               frame_in     = '0;
               countdown_in = '0;
               rsp_mode_in  = start_mode_ff;
            end else begin
               mode_in      = mode_next;
               countdown_in = cd_next;
               rsp_mode_in  = mode_next;
               if (frame_ff != gtces_pkg::FRAME_MAX) frame_in = frame_ff + 1'b1;
            end
            hot_in       = '0;
            cold_in      = '0;
            walk_pos_in  = '0;
            rsp_exit_in  = ex;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // move to the next exchange or report the tile
      if (advance) begin
         if (op.last) begin
            rsp_swaps_in = swaps_ff;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end else begin
            op_idx_in = op_idx_ff + 1'b1;
            state_in  = ST_XA;
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         grid_width_ff  <= gtces_pkg::DIM_RESET;
         grid_height_ff <= gtces_pkg::DIM_RESET;
         start_mode_ff  <= gtces_pkg::MODE_0;
         boring_pct_ff  <= gtces_pkg::BORING_RESET;
         walk_pos_ff    <= '0;
         mode_ff        <= gtces_pkg::MODE_0;
         hot_ff         <= '0;
         cold_ff        <= '0;
         frame_ff       <= '0;
         countdown_ff   <= '0;
         op_idx_ff      <= '0;
         swaps_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         grid_width_ff  <= grid_width_in;
         grid_height_ff <= grid_height_in;
         start_mode_ff  <= start_mode_in;
         boring_pct_ff  <= boring_pct_in;
         walk_pos_ff    <= walk_pos_in;
         mode_ff        <= mode_in;
         hot_ff         <= hot_in;
         cold_ff        <= cold_in;
         frame_ff       <= frame_in;
         countdown_ff   <= countdown_in;
         op_idx_ff      <= op_idx_in;
         swaps_ff       <= swaps_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      pos_ff            <= pos_in;
      vx_ff             <= vx_in;
      chance_ff         <= chance_in;
      hot100_ff         <= hot100_in;
      bpt_ff            <= bpt_in;
      third_ff          <= third_in;
      rsp_read_value_ff <= rsp_read_value_in;
      rsp_rgb_ff        <= rsp_rgb_in;
      rsp_swaps_ff      <= rsp_swaps_in;
      rsp_sweep_ff      <= rsp_sweep_in;
      rsp_exit_ff       <= rsp_exit_in;
      rsp_mode_ff       <= rsp_mode_in;
      rsp_bad_ff        <= rsp_bad_in;
   end

   // Grid memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         pixel_mem[mem_waddr] <= mem_wdata;
      end
      mem_rdata_ff <= pixel_mem[mem_raddr];
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_read_value   = rsp_read_value_ff;
   assign rsp_red          = rsp_rgb_ff.r;
   assign rsp_green        = rsp_rgb_ff.g;
   assign rsp_blue         = rsp_rgb_ff.b;
   assign rsp_swaps_made   = rsp_swaps_ff;
   assign rsp_sweep_done   = rsp_sweep_ff;
   assign rsp_exit_now     = rsp_exit_ff;
   assign rsp_current_mode = rsp_mode_ff;
   assign rsp_bad_index    = rsp_bad_ff;

endmodule

### hdl/gtces_checker.sv
// ----------------------------------------------------------------------------
// Grid tile sorter port checker
// Watches the sorter's ports for item and result ordering and for results
// whose fields contradict each other.
// ----------------------------------------------------------------------------
module gtces_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic                               busy,
   input  logic [1:0]                         req_action,
   input  logic [gtces_pkg::ADDR_W-1:0]       req_pixel_index,
   input  logic [gtces_pkg::HUE_W-1:0]        req_pixel_value,
   input  logic [gtces_pkg::STEP_W-1:0]       req_walk_step,
   input  logic [gtces_pkg::CHANCE_W-1:0]     req_mode_chance,
   input  logic                               rsp_valid,
   input  logic [gtces_pkg::HUE_W-1:0]        rsp_read_value,
   input  logic [gtces_pkg::COLOR_W-1:0]      rsp_red,
   input  logic [gtces_pkg::COLOR_W-1:0]      rsp_green,
   input  logic [gtces_pkg::COLOR_W-1:0]      rsp_blue,
   input  logic [1:0]                         rsp_swaps_made,
   input  logic                               rsp_sweep_done,
   input  logic                               rsp_exit_now,
   input  logic [gtces_pkg::MODE_W-1:0]       rsp_current_mode,
   input  logic                               rsp_bad_index,
   input  logic                               csr_we,
   input  logic [gtces_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [gtces_pkg::DIM_W-1:0]        csr_wdata
);

   // an accepted item either answers at once or holds the block busy
   a_accept_answer: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("accepted item neither answered nor held busy");

   // the block leaves busy only with a result
   a_busy_ends_with_result: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("busy dropped without a result");

   // swaps come only from a sort step that found a tile
   a_swap_exclusive: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_swaps_made != 2'd0)
         |-> (!rsp_sweep_done && !rsp_exit_now && !rsp_bad_index))
      else $error("swap count on a result that could not swap");

   // an off-grid access returns no pixel
   a_bad_index_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_bad_index)
         |-> (rsp_read_value == '0 && rsp_red == '0 && rsp_green == '0 && rsp_blue == '0))
      else $error("off-grid access returned pixel data");

endmodule

bind grid_tile_compare_exchange_sorter gtces_checker u_gtces_checker (.*);
